[design/md2_pkg.sv]
// md2_pkg: shared constants, datapath control types and the MD2 S-box table.
// No dependencies; used by md2_datapath and md2_message_digest_top.
package md2_pkg;

    localparam int BLK_BYTES   = 16;
    localparam int STATE_BYTES = 48;
    localparam int ROUNDS      = 18;

    localparam int FILL_W = $clog2(BLK_BYTES);
    localparam int CNT_W  = $clog2(STATE_BYTES);
    localparam int RND_W  = $clog2(ROUNDS);

    // Datapath operations, one per cycle
    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_SHIFT_BYTE,
        OP_LOAD_CK,
        OP_LOAD_X,
        OP_CK_STEP,
        OP_RND_STEP
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic [7:0]       data_byte;  // byte shifted into the block buffer
        logic             t_zero;     // load: start the round chain from zero
        logic             last;       // final step of a checksum pass or a round
        logic [RND_W-1:0] rnd;        // round number added at the end of a round
    } t_dp_ctrl;

    localparam logic [7:0] SBOX [256] = '{
        8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
        8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
        8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
        8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
        8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
        8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
        8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
        8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
        8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
        8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
        8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
        8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
        8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
        8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
        8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
        8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
        8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
        8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
        8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
        8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
        8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
        8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
        8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
        8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
        8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
        8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
        8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
        8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
        8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
        8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
        8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
        8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
    };

    function automatic logic [7:0] sbox_lookup(input logic [7:0] idx);
        return SBOX[idx];
    endfunction

endpackage

[design/md2_datapath.sv]
// md2_datapath: block buffer, 48-byte hash state and checksum as rotating shift lines,
// with the single shared S-box lookup. Depends on md2_pkg; driven by the top-level sequencer.
module md2_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  md2_pkg::t_dp_ctrl    i_ctrl,
    output logic [7:0]           o_head [md2_pkg::BLK_BYTES]
);

    logic [7:0] r_buf [md2_pkg::BLK_BYTES];
    logic [7:0] n_buf [md2_pkg::BLK_BYTES];
    logic [7:0] r_x   [md2_pkg::STATE_BYTES];
    logic [7:0] n_x   [md2_pkg::STATE_BYTES];
    logic [7:0] r_ck  [md2_pkg::BLK_BYTES];
    logic [7:0] n_ck  [md2_pkg::BLK_BYTES];
    logic [7:0] r_t;
    logic [7:0] n_t;

    logic [7:0] s_idx;
    logic [7:0] s_val;
    logic [7:0] ck_new;
    logic [7:0] x_new;

    // Shared S-box: checksum steps index by buffer head xor chain, rounds by chain
    always_comb begin
        s_idx  = (i_ctrl.op == md2_pkg::OP_CK_STEP) ? (r_buf[0] ^ r_t) : r_t;
        s_val  = md2_pkg::sbox_lookup(s_idx);
        ck_new = r_ck[0] ^ s_val;
        x_new  = r_x[0] ^ s_val;
    end

    // Next-state selection per operation
    always_comb begin
        n_buf = r_buf;
        n_x   = r_x;
        n_ck  = r_ck;
        n_t   = r_t;
        unique case (i_ctrl.op)
            md2_pkg::OP_NONE: begin
            end
            md2_pkg::OP_CLEAR: begin
                n_x  = '{default: '0};
                n_ck = '{default: '0};
                n_t  = '0;
            end
            md2_pkg::OP_SHIFT_BYTE: begin
                for (int i = 0; i < md2_pkg::BLK_BYTES - 1; i++) begin
                    n_buf[i] = r_buf[i+1];
                end
                n_buf[md2_pkg::BLK_BYTES-1] = i_ctrl.data_byte;
            end
            md2_pkg::OP_LOAD_CK: begin
                n_buf = r_ck;
            end
            md2_pkg::OP_LOAD_X: begin
                for (int i = 0; i < md2_pkg::BLK_BYTES; i++) begin
                    n_x[i + md2_pkg::BLK_BYTES]     = r_buf[i];
                    n_x[i + 2 * md2_pkg::BLK_BYTES] = r_buf[i] ^ r_x[i];
                end
                n_t = i_ctrl.t_zero ? 8'd0 : r_ck[md2_pkg::BLK_BYTES-1];
            end
            md2_pkg::OP_CK_STEP: begin
                // rotate buffer, shift checksum with the new byte at the tail
                for (int i = 0; i < md2_pkg::BLK_BYTES - 1; i++) begin
                    n_buf[i] = r_buf[i+1];
                    n_ck[i]  = r_ck[i+1];
                end
                n_buf[md2_pkg::BLK_BYTES-1] = r_buf[0];
                n_ck[md2_pkg::BLK_BYTES-1]  = ck_new;
                n_t = i_ctrl.last ? 8'd0 : ck_new;
            end
            md2_pkg::OP_RND_STEP: begin
                for (int i = 0; i < md2_pkg::STATE_BYTES - 1; i++) begin
                    n_x[i] = r_x[i+1];
                end
                n_x[md2_pkg::STATE_BYTES-1] = x_new;
                n_t = i_ctrl.last ? (x_new + {{(8 - md2_pkg::RND_W){1'b0}}, i_ctrl.rnd})
                                  : x_new;
            end
            default: begin
            end
        endcase
    end

    // Hash state, checksum and chain value reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x  <= '{default: '0};
            r_ck <= '{default: '0};
            r_t  <= '0;
        end else begin
            r_x  <= n_x;
            r_ck <= n_ck;
            r_t  <= n_t;
        end
    end

    // Block buffer needs no reset: padding overwrites unfilled positions
    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    always_comb begin
        for (int i = 0; i < md2_pkg::BLK_BYTES; i++) begin
            o_head[i] = r_x[i];
        end
    end

endmodule

[design/md2_message_digest_top.sv]
// md2_message_digest_top: MD2 digest, one byte per beat, with sequencer and output register.
// Each full block: 1 load step, 16 checksum steps and 18 x 48 S-box steps through the single
// S-box lookup; a byte that completes no block keeps the block ready. End of message: up to 16
// pad bytes, a fold of the pad block, a checksum copy, a fold of the checksum (load and round
// steps only), then emit, later while the previous digest is still held. Not ready while
// padding, folding or emitting. Synchronous active-low reset clears hash state and checksum.
module md2_message_digest_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_high,
    output logic [63:0] o_digest_low
);

    localparam int FW = md2_pkg::FILL_W;
    localparam int CW = md2_pkg::CNT_W;
    localparam int RW = md2_pkg::RND_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_CKSUM,
        S_ROUND,
        S_COPY,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        K_MSG,
        K_PAD,
        K_FINAL
    } t_kind;

    t_state            r_state,   n_state;
    t_kind             r_kind,    n_kind;
    logic [FW-1:0]     r_fill,    n_fill;
    logic              r_end,     n_end;
    logic [FW:0]       r_pad,     n_pad;
    logic [CW-1:0]     r_cnt,     n_cnt;
    logic [RW-1:0]     r_rnd,     n_rnd;
    logic              r_out_valid, n_out_valid;
    logic [63:0]       r_dig_hi,  n_dig_hi;
    logic [63:0]       r_dig_lo,  n_dig_lo;

    md2_pkg::t_dp_ctrl ctrl;
    logic [7:0]        head [md2_pkg::BLK_BYTES];
    logic              in_beat;
    logic              slot_free;
    logic [FW-1:0]     fill_inc;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_beat    = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign fill_inc   = r_fill + 1'b1;

    md2_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_head  (head)
    );

    // Sequencer: next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_fill      = r_fill;
        n_end       = r_end;
        n_pad       = r_pad;
        n_cnt       = r_cnt;
        n_rnd       = r_rnd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_dig_hi    = r_dig_hi;
        n_dig_lo    = r_dig_lo;

        ctrl           = '0;
        ctrl.op        = md2_pkg::OP_NONE;
        ctrl.data_byte = {{(7 - FW){1'b0}}, r_pad};
        ctrl.t_zero    = (r_kind == K_FINAL);
        ctrl.rnd       = r_rnd;

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (i_byte_present) begin
                        ctrl.op        = md2_pkg::OP_SHIFT_BYTE;
                        ctrl.data_byte = i_msg_byte;
                        n_fill         = fill_inc;
                        if (r_fill == FW'(md2_pkg::BLK_BYTES - 1)) begin
                            n_kind  = K_MSG;
                            n_end   = i_end_of_message;
                            n_state = S_LOAD;
                        end else if (i_end_of_message) begin
                            n_pad   = (FW+1)'(md2_pkg::BLK_BYTES) - {1'b0, fill_inc};
                            n_state = S_PAD;
                        end
                    end else if (i_end_of_message) begin
                        n_pad   = (FW+1)'(md2_pkg::BLK_BYTES) - {1'b0, r_fill};
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                ctrl.op = md2_pkg::OP_SHIFT_BYTE;
                n_fill  = fill_inc;
                if (r_fill == FW'(md2_pkg::BLK_BYTES - 1)) begin
                    n_kind  = K_PAD;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                ctrl.op = md2_pkg::OP_LOAD_X;
                n_cnt   = '0;
                n_rnd   = '0;
                n_state = (r_kind == K_FINAL) ? S_ROUND : S_CKSUM;
            end
            S_CKSUM: begin
                ctrl.op   = md2_pkg::OP_CK_STEP;
                ctrl.last = (r_cnt == CW'(md2_pkg::BLK_BYTES - 1));
                n_cnt     = r_cnt + 1'b1;
                if (ctrl.last) begin
                    n_cnt   = '0;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                ctrl.op   = md2_pkg::OP_RND_STEP;
                ctrl.last = (r_cnt == CW'(md2_pkg::STATE_BYTES - 1));
                n_cnt     = r_cnt + 1'b1;
                if (ctrl.last) begin
                    n_cnt = '0;
                    n_rnd = r_rnd + 1'b1;
                    if (r_rnd == RW'(md2_pkg::ROUNDS - 1)) begin
                        unique case (r_kind)
                            K_MSG: begin
                                // block done; a pending end pads a whole block
                                if (r_end) begin
                                    n_pad   = (FW+1)'(md2_pkg::BLK_BYTES);
                                    n_state = S_PAD;
                                end else begin
                                    n_state = S_IDLE;
                                end
                            end
                            K_PAD:   n_state = S_COPY;
                            K_FINAL: n_state = S_EMIT;
                            default: n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_COPY: begin
                ctrl.op = md2_pkg::OP_LOAD_CK;
                n_kind  = K_FINAL;
                n_state = S_LOAD;
            end
            S_EMIT: begin
                if (slot_free) begin
                    for (int i = 0; i < 8; i++) begin
                        n_dig_hi[63 - 8*i -: 8] = head[i];
                        n_dig_lo[63 - 8*i -: 8] = head[i + 8];
                    end
                    n_out_valid = 1'b1;
                    ctrl.op     = md2_pkg::OP_CLEAR;
                    n_fill      = '0;
                    n_end       = 1'b0;
                    n_kind      = K_MSG;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= K_MSG;
            r_fill      <= '0;
            r_end       <= 1'b0;
            r_cnt       <= '0;
            r_rnd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_fill      <= n_fill;
            r_end       <= n_end;
            r_cnt       <= n_cnt;
            r_rnd       <= n_rnd;
            r_out_valid <= n_out_valid;
        end
        r_pad    <= n_pad;
        r_dig_hi <= n_dig_hi;
        r_dig_lo <= n_dig_lo;
    end

    assign o_out_valid   = r_out_valid;
    assign o_digest_high = r_dig_hi;
    assign o_digest_low  = r_dig_lo;

endmodule

[verif/md2_message_digest_checker.sv]
`timescale 1ns / 1ps
// md2_message_digest_checker: watches the message and digest beat channels of the MD2 block,
// works out each digest from the accepted message beats and compares it field by field.
// Stand-alone apart from the signals it watches; instantiated by md2_message_digest_top_tb.
module md2_message_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [63:0] i_digest_high,
    input  logic [63:0] i_digest_low,
    output int          o_errors,
    output int          o_outstanding
);

    localparam int BLOCK_LEN  = 16;
    localparam int STATE_LEN  = 48;
    localparam int NUM_ROUNDS = 18;

    // MD2 substitution table, built from the digits of pi
    localparam logic [7:0] PI_SUBST [256] = '{
        8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
        8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
        8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
        8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
        8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
        8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
        8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
        8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
        8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
        8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
        8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
        8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
        8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
        8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
        8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
        8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
        8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
        8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
        8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
        8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
        8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
        8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
        8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
        8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
        8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
        8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
        8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
        8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
        8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
        8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
        8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
        8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
    };

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] low;
    } t_digest;

    // Predicted block state; msg_block holds byte i at bits [8*i +: 8]
    logic [127:0] msg_block;
    int           fill_level;
    logic [7:0]   hash_x    [STATE_LEN];
    logic [7:0]   check_sum [BLOCK_LEN];

    t_digest      digests_due [$];
    int           err_count = 0;
    int           due_count = 0;

    assign o_errors      = err_count;
    assign o_outstanding = due_count;

    task automatic flag_error(input string what);
        $display("ERROR %0t: %s", $time, what);
        err_count++;
    endtask

    task automatic clear_hash();
        msg_block  = '0;
        fill_level = 0;
        for (int i = 0; i < STATE_LEN; i++) hash_x[i] = 8'h00;
        for (int i = 0; i < BLOCK_LEN; i++) check_sum[i] = 8'h00;
    endtask

    // One 16-byte block through the 18-round transform, then into the checksum
    task automatic fold_block(input logic [127:0] blk);
        logic [7:0] t;
        for (int i = 0; i < BLOCK_LEN; i++) begin
            hash_x[i + 16] = blk[8*i +: 8];
            hash_x[i + 32] = blk[8*i +: 8] ^ hash_x[i];
        end
        t = 8'h00;
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            for (int i = 0; i < STATE_LEN; i++) begin
                hash_x[i] = hash_x[i] ^ PI_SUBST[t];
                t = hash_x[i];
            end
            t = t + r[7:0];
        end
        t = check_sum[BLOCK_LEN - 1];
        for (int i = 0; i < BLOCK_LEN; i++) begin
            check_sum[i] = check_sum[i] ^ PI_SUBST[blk[8*i +: 8] ^ t];
            t = check_sum[i];
        end
    endtask

    // Absorb one message beat; at the end of a message, pad, finish and queue the digest
    task automatic take_beat(input logic [7:0] b, input logic present, input logic last);
        logic [7:0]   pad;
        logic [127:0] sum_blk;
        t_digest      d;
        if (present) begin
            msg_block[8*fill_level +: 8] = b;
            fill_level++;
            if (fill_level == BLOCK_LEN) begin
                fold_block(msg_block);
                fill_level = 0;
            end
        end
        if (last) begin
            // an empty buffer pads out to a whole block of sixteens
            pad = 8'(BLOCK_LEN - fill_level);
            for (int k = fill_level; k < BLOCK_LEN; k++) msg_block[8*k +: 8] = pad;
            fold_block(msg_block);
            for (int k = 0; k < BLOCK_LEN; k++) sum_blk[8*k +: 8] = check_sum[k];
            fold_block(sum_blk);
            d = '0;
            for (int k = 0; k < 8; k++) begin
                d.high = {d.high[55:0], hash_x[k]};
                d.low  = {d.low[55:0], hash_x[k + 8]};
            end
            digests_due.push_back(d);
            clear_hash();
        end
    endtask

    // Channel monitor: digest beat is checked before the message beat of the same edge
    always @(posedge i_clk) begin : watch
        logic    popped;
        logic    pushed;
        t_digest want;
        if (!i_rst_n) begin
            clear_hash();
            digests_due.delete();
            due_count <= 0;
        end else begin
            popped = 1'b0;
            pushed = 1'b0;
            if (i_out_valid && i_out_ready) begin
                if (digests_due.size() == 0) begin
                    flag_error($sformatf("digest %h %h with none predicted",
                                         i_digest_high, i_digest_low));
                end else begin
                    want   = digests_due.pop_front();
                    popped = 1'b1;
                    if (i_digest_high !== want.high)
                        flag_error($sformatf("digest_high %h, predicted %h",
                                             i_digest_high, want.high));
                    if (i_digest_low !== want.low)
                        flag_error($sformatf("digest_low %h, predicted %h",
                                             i_digest_low, want.low));
                end
            end
            if (i_in_valid && i_in_ready) begin
                take_beat(i_msg_byte, i_byte_present, i_end_of_message);
                pushed = i_end_of_message;
            end
            due_count <= due_count + int'(pushed) - int'(popped);
        end
    end

endmodule

[verif/md2_message_digest_top_tb.sv]
`timescale 1ns / 1ps
// md2_message_digest_top_tb: drives message beats into md2_message_digest_top and gives the verdict.
// Depends on the block and on md2_message_digest_checker, which predicts and compares digests.
module md2_message_digest_top_tb;

    localparam int ITEMS_PER_PHASE  = 600;
    localparam int LONG_HOLD_CYCLES = 30000;
    localparam int SETTLE_CYCLES    = 2000;
    localparam int TIMEOUT_NS       = 300_000_000;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [7:0]  msg_byte       = 8'h00;
    logic        byte_present   = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [63:0] digest_high;
    logic [63:0] digest_low;

    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    logic        hold_req       = 1'b0;
    int          beats_taken    = 0;
    int          errors;
    int          digests_pending;

    md2_message_digest_top dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_msg_byte       (msg_byte),
        .i_byte_present   (byte_present),
        .i_end_of_message (end_of_message),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_digest_high    (digest_high),
        .o_digest_low     (digest_low)
    );

    md2_message_digest_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_msg_byte       (msg_byte),
        .i_byte_present   (byte_present),
        .i_end_of_message (end_of_message),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_digest_high    (digest_high),
        .i_digest_low     (digest_low),
        .o_errors         (errors),
        .o_outstanding    (digests_pending)
    );

    // 100 MHz clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up if the run hangs
    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Digest receiver: random back-pressure, or one long hold-off on request
    initial begin : receiver
        bit hold_used;
        hold_used = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // One message beat, after a random gap; returns at the edge that takes it
    task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        msg_byte       <= b;
        byte_present   <= present;
        end_of_message <= last;
        do @(posedge clk); while (!in_ready);
        if (present || last) beats_taken++;
    endtask

    // Whole message of random length and content, with the odd empty beat between bytes
    task automatic random_message();
        int         len;
        int         pick;
        int         fill_mode;
        bit         last_on_byte;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 60)      len = $urandom_range(0, 20);
        else if (pick < 85) len = $urandom_range(12, 40);
        else if (pick < 97) len = $urandom_range(41, 80);
        else                len = $urandom_range(100, 200);
        last_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        fill_mode    = $urandom_range(0, 9);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
            case (fill_mode)
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_beat(b, 1'b1, last_on_byte && (k == len - 1));
        end
        // end marker without a byte
        if (!last_on_byte) send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    // Stop offering and wait for every predicted digest
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (digests_pending != 0);
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input bit long_hold);
        send_idle_pct = s_pct;
        recv_idle_pct <= r_pct;
        if (long_hold) hold_req <= 1'b1;
        beats_taken = 0;
        while (beats_taken < ITEMS_PER_PHASE) random_message();
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 13;
        recv_idle_pct <= 82;

        // Directed: empty message, stray empty beat, single 0xFF, 0x00 then empty end,
        // and a full block whose last byte ends the message (whole pad block follows)
        send_beat(8'hA5, 1'b0, 1'b1);
        send_beat(8'h3C, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h5A, 1'b0, 1'b1);
        for (int k = 0; k < 16; k++) send_beat(8'(k * 17), 1'b1, k == 15);
        wait_drained();

        // Random messages: slow receiver, then slow sender, then flat out with a long stall
        run_phase(13, 82, 1'b0);
        run_phase(82, 13, 1'b0);
        run_phase(0, 0, 1'b1);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && digests_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
